[rtl/core/lsfe_pkg.sv]
// Package with the shared types, constants and request codes of the LED strip frame encoder.
package lsfe_pkg;

  // Block dimensions.
  localparam int unsigned LED_COUNT   = 16;
  localparam int unsigned LEAD_SLOTS  = 64;
  localparam int unsigned FRAME_BYTES = 512;

  // Pixel store index, LED counter (holds LED_COUNT itself) and frame counter widths.
  localparam int unsigned IDX_W   = (LED_COUNT > 1) ? $clog2(LED_COUNT) : 1;
  localparam int unsigned LED_W   = $clog2(LED_COUNT + 1);
  localparam int unsigned FRAME_W = $clog2(FRAME_BYTES);

  // Request codes.
  localparam logic [1:0] REQ_WRITE = 2'd0;
  localparam logic [1:0] REQ_CLEAR = 2'd1;
  localparam logic [1:0] REQ_START = 2'd2;
  localparam logic [1:0] REQ_TICK  = 2'd3;

  // Configuration register indexes.
  localparam int unsigned CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] CFG_PATTERN_ONE  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PATTERN_ZERO = 1'd1;

  // Configuration reset values.
  localparam logic [7:0] PATTERN_ONE_RST  = 8'd248;
  localparam logic [7:0] PATTERN_ZERO_RST = 8'd192;

  // Color channel positions within a pixel.
  localparam logic [1:0] COLOR_GREEN = 2'd0;
  localparam logic [1:0] COLOR_RED   = 2'd1;
  localparam logic [1:0] COLOR_BLUE  = 2'd2;

  typedef struct packed {
    logic [1:0] req_type;
    logic [7:0] pixel_index;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } in_item_t;

  typedef struct packed {
    logic [7:0] serial_byte;
    logic       frame_end;
  } out_item_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic write_px;
    logic clear_all;
    logic restart;
    logic advance;
    logic emit;
    logic last;
  } ctl_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic led_done;
  } dp_status_t;

endpackage

[rtl/core/led_strip_spi_frame_encoder.sv]
// Top level of the LED strip frame encoder: command port, configuration port and result strobe.
//
// The block holds one 24-bit color per LED (green, red, blue), all zero after reset.
// Items arrive on the command port: in_data is taken at a clock edge where start is high
// and busy is low. busy never rises, so an item can be given in every cycle. An item
// writes one pixel (indexes at or above the LED count are dropped), clears all pixels,
// starts a refresh, or is a transmitter tick. Writes, clears and starts during a refresh
// are dropped.
// During a refresh each tick yields one frame byte on out_data, marked by out_valid for
// exactly one cycle, the cycle after the tick was taken (one item per cycle, as the
// pixel read and bit select are combinational). A frame is the lead-in
// zero bytes, then each LED's green, red and blue bits MSB first, every bit sent as the
// pattern_one or pattern_zero byte, then zero padding up to the frame length; the last
// byte carries frame_end, after which the block is idle again.
// The receiver cannot stall: each result is taken in the cycle it is shown.
// The configuration port (cfg_valid/cfg_ready, always ready) writes pattern_one at
// index 0 and pattern_zero at index 1; write it only while no refresh is running.
// Synchronous active-low reset clears the pixels, ends any refresh and restores the
// default patterns.
module led_strip_spi_frame_encoder (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  output logic                           busy,
  input  lsfe_pkg::in_item_t             in_data,
  output logic                           out_valid,
  output lsfe_pkg::out_item_t            out_data,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [lsfe_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [7:0]                     cfg_data
);
  import lsfe_pkg::*;

  ctl_cmd_t   cmd;
  dp_status_t status;
  logic       accept;

  // No item holds the sender off once it is taken, so the block is never busy.
  assign busy      = 1'b0;
  assign cfg_ready = 1'b1;
  assign accept    = start && !busy;

  lsfe_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .accept   (accept),
    .req_type (in_data.req_type),
    .status   (status),
    .cmd      (cmd)
  );

  lsfe_datapath u_datapath (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .in_item   (in_data),
    .cfg_we    (cfg_valid && cfg_ready),
    .cfg_idx   (cfg_index),
    .cfg_wdata (cfg_data),
    .status    (status),
    .out_valid (out_valid),
    .out_item  (out_data)
  );

endmodule

[rtl/core/lsfe_ctrl.sv]
// Controller of the LED strip frame encoder: refresh state and frame byte counter.
module lsfe_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                accept,
  input  logic [1:0]          req_type,
  input  lsfe_pkg::dp_status_t status,
  output lsfe_pkg::ctl_cmd_t   cmd
);
  import lsfe_pkg::*;

  localparam logic ST_IDLE    = 1'b0;
  localparam logic ST_REFRESH = 1'b1;

  logic               state_r, state_nxt;
  logic [FRAME_W-1:0] frame_pos_r, frame_pos_nxt;
  logic               data_phase;
  logic               frame_last;

  assign data_phase = (32'(frame_pos_r) >= LEAD_SLOTS) && !status.led_done;
  assign frame_last = (frame_pos_r == FRAME_W'(FRAME_BYTES - 1));

  always_comb begin
    state_nxt     = state_r;
    frame_pos_nxt = frame_pos_r;
    cmd           = '0;
    if (accept) begin
      unique case (state_r)
        ST_IDLE: begin
          unique case (req_type)
            REQ_WRITE: cmd.write_px  = 1'b1;
            REQ_CLEAR: cmd.clear_all = 1'b1;
            REQ_START: begin
              cmd.restart   = 1'b1;
              frame_pos_nxt = '0;
              state_nxt     = ST_REFRESH;
            end
            REQ_TICK: ;
            default: ;
          endcase
        end
        ST_REFRESH: begin
          // Only ticks count while a frame is going out.
          if (req_type == REQ_TICK) begin
            cmd.emit    = 1'b1;
            cmd.advance = data_phase;
            cmd.last    = frame_last;
            if (frame_last) begin
              cmd.restart   = 1'b1;
              frame_pos_nxt = '0;
              state_nxt     = ST_IDLE;
            end else begin
              frame_pos_nxt = frame_pos_r + 1'b1;
            end
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      frame_pos_r <= '0;
    end else begin
      state_r     <= state_nxt;
      frame_pos_r <= frame_pos_nxt;
    end
  end

endmodule

[rtl/core/lsfe_datapath.sv]
// Datapath of the LED strip frame encoder: pixel store, bit walk, patterns and output register.
module lsfe_datapath (
  input  logic                          clk,
  input  logic                          rst_n,
  input  lsfe_pkg::ctl_cmd_t            cmd,
  input  lsfe_pkg::in_item_t            in_item,
  input  logic                          cfg_we,
  input  logic [lsfe_pkg::CFG_IDX_W-1:0] cfg_idx,
  input  logic [7:0]                    cfg_wdata,
  output lsfe_pkg::dp_status_t          status,
  output logic                          out_valid,
  output lsfe_pkg::out_item_t           out_item
);
  import lsfe_pkg::*;

  logic [23:0]      pixel_r [LED_COUNT];
  logic [LED_W-1:0] led_pos_r, led_pos_nxt;
  logic [1:0]       color_pos_r, color_pos_nxt;
  logic [2:0]       bit_pos_r, bit_pos_nxt;
  logic [7:0]       pat_one_r, pat_zero_r;
  logic             valid_r;
  out_item_t        item_r;
  logic [23:0]      cur_pixel;
  logic [7:0]       channel;
  logic             data_bit;
  logic             px_in_range;

  assign status.led_done = (led_pos_r == LED_W'(LED_COUNT));
  assign px_in_range     = (32'(in_item.pixel_index) < LED_COUNT);

  // The pixel is only used while LEDs remain, and the index is always in range.
  assign cur_pixel = pixel_r[led_pos_r[IDX_W-1:0]];

  always_comb begin
    unique case (color_pos_r)
      COLOR_GREEN: channel = cur_pixel[23:16];
      COLOR_RED:   channel = cur_pixel[15:8];
      COLOR_BLUE:  channel = cur_pixel[7:0];
      default:     channel = '0;
    endcase
  end

  assign data_bit = channel[3'd7 - bit_pos_r];

  // Bits go MSB first, colors green, red, blue, then the next LED.
  always_comb begin
    led_pos_nxt   = led_pos_r;
    color_pos_nxt = color_pos_r;
    bit_pos_nxt   = bit_pos_r;
    if (cmd.restart) begin
      led_pos_nxt   = '0;
      color_pos_nxt = COLOR_GREEN;
      bit_pos_nxt   = '0;
    end else if (cmd.advance) begin
      bit_pos_nxt = bit_pos_r + 1'b1;
      if (bit_pos_r == 3'd7) begin
        if (color_pos_r == COLOR_BLUE) begin
          color_pos_nxt = COLOR_GREEN;
          led_pos_nxt   = led_pos_r + 1'b1;
        end else begin
          color_pos_nxt = color_pos_r + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < LED_COUNT; i++) begin
        pixel_r[i] <= '0;
      end
    end else if (cmd.clear_all) begin
      for (int i = 0; i < LED_COUNT; i++) begin
        pixel_r[i] <= '0;
      end
    end else if (cmd.write_px && px_in_range) begin
      pixel_r[in_item.pixel_index[IDX_W-1:0]] <= {in_item.green, in_item.red, in_item.blue};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      led_pos_r   <= '0;
      color_pos_r <= COLOR_GREEN;
      bit_pos_r   <= '0;
      pat_one_r   <= PATTERN_ONE_RST;
      pat_zero_r  <= PATTERN_ZERO_RST;
      valid_r     <= 1'b0;
    end else begin
      led_pos_r   <= led_pos_nxt;
      color_pos_r <= color_pos_nxt;
      bit_pos_r   <= bit_pos_nxt;
      valid_r     <= cmd.emit;
      if (cfg_we) begin
        unique case (cfg_idx)
          CFG_PATTERN_ONE:  pat_one_r  <= cfg_wdata;
          CFG_PATTERN_ZERO: pat_zero_r <= cfg_wdata;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      item_r.serial_byte <= cmd.advance ? (data_bit ? pat_one_r : pat_zero_r) : 8'h00;
      item_r.frame_end   <= cmd.last;
    end
  end

  assign out_valid = valid_r;
  assign out_item  = item_r;

endmodule

[verif/tb_led_strip_spi_frame_encoder.sv]
// Self-checking testbench for the LED strip frame encoder: directed rows, then random frames.
module tb_led_strip_spi_frame_encoder;
  import lsfe_pkg::*;

  // Random traffic stops after this many items, dropped ones included.
  // The last QUIET_TAIL of them run without any random sender gaps.
  localparam int unsigned RANDOM_ITEMS = 1130;
  localparam int unsigned QUIET_TAIL   = 200;
  // Cycles without any handshake before the run is declared hung.
  localparam int unsigned STALL_LIMIT  = 1000;
  // Only the first mismatches are printed; the rest are just counted.
  localparam int unsigned PRINT_LIMIT  = 40;

  // How a directed row is checked: no byte at all, a byte typed into the row,
  // or whatever the frame predictor says.
  typedef enum logic [1:0] {
    ROW_SILENT,
    ROW_TYPED,
    ROW_PREDICT
  } row_check_e;

  typedef struct {
    in_item_t   item;
    row_check_e how;
    out_item_t  want;
  } script_row_t;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 start = 1'b0;
  logic                 busy;
  in_item_t             in_data = '0;
  logic                 out_valid;
  out_item_t            out_data;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = CFG_PATTERN_ONE;
  logic [7:0]           cfg_data = '0;

  // Shadow copy of the encoder: pixel colors, refresh flag, frame counters, patterns.
  logic [23:0]        led_rgb [LED_COUNT];
  bit                 strip_refresh;
  logic [FRAME_W-1:0] frame_pos;
  logic [LED_W-1:0]   led_pos;
  logic [1:0]         color_pos;
  logic [2:0]         bit_pos;
  logic [7:0]         pat_one;
  logic [7:0]         pat_zero;

  // Frame bytes predicted but not yet seen on the output, oldest first.
  out_item_t frame_bytes_due[$];

  int unsigned mismatch_count;
  int unsigned items_sent;
  int unsigned random_items;
  int unsigned bytes_checked;
  int unsigned frames_done;
  int unsigned settings_used;
  int unsigned stall_cycles;
  bit          gaps_on;

  led_strip_spi_frame_encoder uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  task automatic flag_mismatch(input string what);
    if (mismatch_count < PRINT_LIMIT) begin
      $display("mismatch at %0t: %s", $realtime, what);
    end
    mismatch_count++;
  endtask

  function automatic void rewind_frame();
    frame_pos = '0;
    led_pos   = '0;
    color_pos = COLOR_GREEN;
    bit_pos   = '0;
  endfunction

  // Applies one accepted item to the shadow state. Returns 1 when the item yields a
  // frame byte, which is then placed in res.
  function automatic bit predict_frame_byte(input in_item_t it, output out_item_t res);
    logic [23:0] px;
    logic [7:0]  chan;
    res = '0;
    if (it.req_type != REQ_TICK) begin
      // Writes, clears and starts are dropped while a frame is going out.
      if (!strip_refresh) begin
        case (it.req_type)
          REQ_WRITE: begin
            if (it.pixel_index < LED_COUNT) begin
              led_rgb[it.pixel_index[IDX_W-1:0]] = {it.green, it.red, it.blue};
            end
          end
          REQ_CLEAR: begin
            foreach (led_rgb[i]) led_rgb[i] = '0;
          end
          REQ_START: begin
            strip_refresh = 1'b1;
            rewind_frame();
          end
          default: ;
        endcase
      end
      return 1'b0;
    end
    // A tick outside a refresh is simply dropped.
    if (!strip_refresh) return 1'b0;
    // Past the lead-in, and while LEDs remain, every tick sends one data bit as a pattern.
    if (frame_pos >= LEAD_SLOTS && led_pos < LED_COUNT) begin
      px = led_rgb[led_pos[IDX_W-1:0]];
      case (color_pos)
        COLOR_GREEN: chan = px[23:16];
        COLOR_RED:   chan = px[15:8];
        default:     chan = px[7:0];
      endcase
      res.serial_byte = chan[3'd7 - bit_pos] ? pat_one : pat_zero;
      if (bit_pos == 3'd7) begin
        bit_pos = '0;
        if (color_pos == COLOR_BLUE) begin
          color_pos = COLOR_GREEN;
          led_pos++;
        end else begin
          color_pos++;
        end
      end else begin
        bit_pos++;
      end
    end
    res.frame_end = (frame_pos >= FRAME_BYTES - 1);
    if (res.frame_end) begin
      strip_refresh = 1'b0;
      rewind_frame();
      frames_done++;
    end else begin
      frame_pos++;
    end
    return 1'b1;
  endfunction

  // Color values lean toward the all-zero and all-one bytes.
  function automatic logic [7:0] rand_byte();
    case ($urandom_range(0, 7))
      0:       return 8'h00;
      1:       return 8'hFF;
      default: return 8'($urandom);
    endcase
  endfunction

  function automatic in_item_t make_item(input logic [1:0] req, input logic [7:0] idx);
    in_item_t it;
    it.req_type    = req;
    it.pixel_index = idx;
    it.red         = rand_byte();
    it.green       = rand_byte();
    it.blue        = rand_byte();
    return it;
  endfunction

  function automatic script_row_t row(input logic [1:0] req, input logic [7:0] idx,
                                      input logic [7:0] r, input logic [7:0] g,
                                      input logic [7:0] b, input row_check_e how,
                                      input logic [7:0] sbyte, input logic fend);
    script_row_t s;
    s.item      = '{req_type: req, pixel_index: idx, red: r, green: g, blue: b};
    s.how       = how;
    s.want      = '{serial_byte: sbyte, frame_end: fend};
    return s;
  endfunction

  // Presents one item and holds it until the block takes it. start is left high so that
  // back-to-back items need no second assignment in the same step.
  task automatic send_item(input in_item_t it, output bit got, output out_item_t res);
    start   <= 1'b1;
    in_data <= it;
    do @(posedge clk); while (busy);
    items_sent++;
    got = predict_frame_byte(it, res);
  endtask

  // Random-traffic send: an optional idle burst first, then the item.
  task automatic feed(input in_item_t it);
    bit        got;
    out_item_t res;
    if (gaps_on && random_items + QUIET_TAIL < RANDOM_ITEMS && $urandom_range(0, 2) == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk);
    end
    send_item(it, got, res);
    if (got) frame_bytes_due.push_back(res);
    random_items++;
  endtask

  // Holds the sender off until every predicted byte has appeared, then lets the
  // registered output settle for anything that yields no byte.
  task automatic drain_pipeline();
    start <= 1'b0;
    while (frame_bytes_due.size() != 0) @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  // Writes both pattern registers back to back; only called while the block is idle.
  task automatic program_patterns(input logic [7:0] one_val, input logic [7:0] zero_val);
    cfg_valid <= 1'b1;
    cfg_index <= CFG_PATTERN_ONE;
    cfg_data  <= one_val;
    do @(posedge clk); while (!cfg_ready);
    pat_one = one_val;
    cfg_index <= CFG_PATTERN_ZERO;
    cfg_data  <= zero_val;
    do @(posedge clk); while (!cfg_ready);
    pat_zero = zero_val;
    cfg_valid <= 1'b0;
    settings_used++;
  endtask

  // Random part. Between frames the patterns are reprogrammed and a fresh set of pixels
  // is loaded before the next start; during a frame the traffic is mostly ticks, mixed
  // with writes, clears and starts that the block must drop.
  task automatic random_traffic();
    int unsigned n_writes;
    int unsigned setting_no;
    setting_no = 0;
    while (random_items < RANDOM_ITEMS) begin
      if (!strip_refresh) begin
        drain_pipeline();
        // The first two random frames take the pattern extremes, later ones random patterns.
        case (setting_no)
          0:       program_patterns(8'hFF, 8'h00);
          1:       program_patterns(8'h00, 8'hFF);
          default: program_patterns(rand_byte(), rand_byte());
        endcase
        setting_no++;
        gaps_on = ($urandom_range(0, 2) != 0);
        if ($urandom_range(0, 3) == 0) feed(make_item(REQ_CLEAR, 8'($urandom)));
        n_writes = $urandom_range(1, 24);
        repeat (n_writes) begin
          case ($urandom_range(0, 9))
            0:       feed(make_item(REQ_WRITE, 8'($urandom_range(LED_COUNT, 255))));
            1:       feed(make_item(REQ_TICK, 8'($urandom)));
            default: feed(make_item(REQ_WRITE, 8'($urandom_range(0, LED_COUNT - 1))));
          endcase
        end
        feed(make_item(REQ_START, 8'($urandom)));
      end else begin
        // Now and then the sender waits for every byte still owed.
        if (random_items + QUIET_TAIL < RANDOM_ITEMS && $urandom_range(0, 199) == 0) begin
          drain_pipeline();
        end
        if ($urandom_range(0, 99) == 0) gaps_on = !gaps_on;
        if ($urandom_range(0, 7) == 0) begin
          feed(make_item(2'($urandom_range(0, 2)), 8'($urandom)));
        end else begin
          feed(make_item(REQ_TICK, 8'($urandom)));
        end
      end
    end
  endtask

  // Output side: the receiver takes every byte in the cycle it is shown, so each strobe
  // is matched against the oldest predicted byte.
  always @(posedge clk) begin
    out_item_t want;
    if (rst_n && out_valid) begin
      if (frame_bytes_due.size() == 0) begin
        flag_mismatch($sformatf("unexpected byte %02h frame_end %0b",
                                out_data.serial_byte, out_data.frame_end));
      end else begin
        want = frame_bytes_due.pop_front();
        bytes_checked++;
        if (out_data.serial_byte !== want.serial_byte) begin
          flag_mismatch($sformatf("serial_byte %02h, predicted %02h",
                                  out_data.serial_byte, want.serial_byte));
        end
        if (out_data.frame_end !== want.frame_end) begin
          flag_mismatch($sformatf("frame_end %0b, predicted %0b",
                                  out_data.frame_end, want.frame_end));
        end
      end
    end
  end

  // Watchdog: any handshake on any port resets the count of silent cycles.
  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid || (cfg_valid && cfg_ready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("timeout: no handshake for %0d cycles", stall_cycles);
      $display("tb: failure");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin
    script_row_t script[$];
    out_item_t   res;
    bit          got;

    foreach (led_rgb[i]) led_rgb[i] = '0;
    strip_refresh = 1'b0;
    rewind_frame();
    pat_one  = PATTERN_ONE_RST;
    pat_zero = PATTERN_ZERO_RST;
    gaps_on  = 1'b0;

    // Directed rows run with the reset patterns. A tick with no refresh running, pixel
    // writes at both ends of the strip and past it, a clear, another idle tick and fresh
    // writes, then a start. Inside the frame, writes, clears and a second start must all
    // be dropped. Lead-in bytes are zero, so those rows carry their byte directly.
    script.push_back(row(REQ_TICK,  8'hFF, 8'hFF, 8'hFF, 8'hFF, ROW_SILENT, 8'h00, 1'b0));
    script.push_back(row(REQ_WRITE, 8'd0,  8'h00, 8'hFF, 8'h80, ROW_SILENT, 8'h00, 1'b0));
    script.push_back(row(REQ_WRITE, 8'(LED_COUNT - 1), 8'hFF, 8'h00, 8'h01,
                         ROW_SILENT, 8'h00, 1'b0));
    script.push_back(row(REQ_WRITE, 8'(LED_COUNT), 8'hFF, 8'hFF, 8'hFF,
                         ROW_SILENT, 8'h00, 1'b0));
    script.push_back(row(REQ_WRITE, 8'hFF, 8'hAA, 8'h55, 8'hFF, ROW_SILENT, 8'h00, 1'b0));
    script.push_back(row(REQ_CLEAR, 8'h00, 8'h00, 8'h00, 8'h00, ROW_SILENT, 8'h00, 1'b0));
    script.push_back(row(REQ_TICK,  8'h00, 8'h00, 8'h00, 8'h00, ROW_SILENT, 8'h00, 1'b0));
    script.push_back(row(REQ_WRITE, 8'd0,  8'h5A, 8'hA5, 8'hFF, ROW_SILENT, 8'h00, 1'b0));
    script.push_back(row(REQ_WRITE, 8'(LED_COUNT - 1), 8'h00, 8'hFF, 8'h80,
                         ROW_SILENT, 8'h00, 1'b0));
    script.push_back(row(REQ_WRITE, 8'd7,  8'h6C, 8'h93, 8'h3E, ROW_PREDICT, 8'h00, 1'b0));
    script.push_back(row(REQ_WRITE, 8'd8,  8'h01, 8'h80, 8'h7F, ROW_PREDICT, 8'h00, 1'b0));
    script.push_back(row(REQ_START, 8'h00, 8'h00, 8'h00, 8'h00, ROW_SILENT, 8'h00, 1'b0));
    script.push_back(row(REQ_TICK,  8'h00, 8'h00, 8'h00, 8'h00, ROW_TYPED,  8'h00, 1'b0));
    script.push_back(row(REQ_WRITE, 8'd0,  8'h00, 8'h00, 8'h00, ROW_SILENT, 8'h00, 1'b0));
    script.push_back(row(REQ_CLEAR, 8'hFF, 8'hFF, 8'hFF, 8'hFF, ROW_SILENT, 8'h00, 1'b0));
    script.push_back(row(REQ_START, 8'h00, 8'h00, 8'h00, 8'h00, ROW_SILENT, 8'h00, 1'b0));
    script.push_back(row(REQ_TICK,  8'hFF, 8'hFF, 8'hFF, 8'hFF, ROW_TYPED,  8'h00, 1'b0));
    script.push_back(row(REQ_WRITE, 8'(LED_COUNT - 1), 8'h12, 8'h34, 8'h56,
                         ROW_SILENT, 8'h00, 1'b0));
    script.push_back(row(REQ_TICK,  8'h00, 8'h00, 8'h00, 8'h00, ROW_PREDICT, 8'h00, 1'b0));

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (script[i]) begin
      send_item(script[i].item, got, res);
      case (script[i].how)
        ROW_TYPED:   frame_bytes_due.push_back(script[i].want);
        ROW_PREDICT: if (got) frame_bytes_due.push_back(res);
        default: ;
      endcase
    end

    // The directed frame is still running here; the random part finishes it first.
    random_traffic();

    start <= 1'b0;
    while (frame_bytes_due.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);

    $display("covered: %0d items (%0d directed), %0d frame bytes compared",
             items_sent, script.size(), bytes_checked);
    $display("covered: %0d complete frames under %0d programmed pattern pairs plus reset values",
             frames_done, settings_used);
    if (mismatch_count == 0) begin
      $display("tb: success");
    end else begin
      $display("%0d mismatches", mismatch_count);
      $display("tb: failure");
    end
    $finish;
  end

endmodule
